// ===== design/mfr_pkg.sv =====
// Shared constants and types for the message frame receiver.
package mfr_pkg;

  localparam int MESSAGE_CAPACITY = 64;
  localparam int ID_TEXT_LIMIT    = 6;

  localparam int COUNT_W    = $clog2(MESSAGE_CAPACITY + 1);
  localparam int ID_CHAR_W  = $clog2(ID_TEXT_LIMIT + 1);
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ID_W       = 16;
  localparam int INDEX_W    = 7;
  localparam int ACC_W      = 20;
  localparam int TDATA_W    = 32;

  typedef struct packed {
    logic                      valid;
    logic [KIND_W-1:0]         kind;
    logic signed [ID_W-1:0]    message_id;
    logic [BYTE_W-1:0]         payload_byte;
    logic [INDEX_W-1:0]        byte_index;
  } mfr_result_t;

endpackage

// ===== design/mfr_core.sv =====
// Frame parser state and the per-byte next-state and result logic.
module mfr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [mfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       end_of_transfer,
  output mfr_pkg::mfr_result_t       res
);
  import mfr_pkg::*;

  localparam logic [1:0] PH_NOSYNC  = 2'd0;
  localparam logic [1:0] PH_ID      = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] ST_SPACE   = 2'd0;
  localparam logic [1:0] ST_SIGNED  = 2'd1;
  localparam logic [1:0] ST_DIGITS  = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_PAYLOAD_END = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ID_END      = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_PARTIAL_END = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE       = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB         = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_FORM_FEED   = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_PLUS        = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS       = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO        = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE        = 8'h39;

  localparam logic [ID_CHAR_W-1:0] ID_LIMIT = ID_CHAR_W'(ID_TEXT_LIMIT);
  localparam logic [COUNT_W-1:0]   CAP      = COUNT_W'(MESSAGE_CAPACITY);

  logic [1:0]           phase, phase_next;
  logic [ID_CHAR_W-1:0] id_char_count, id_char_count_next;
  logic [ACC_W-1:0]     id_accumulator, id_accumulator_next;
  logic                 id_negative, id_negative_next;
  logic [1:0]           id_scan_stage, id_scan_stage_next;
  logic [ID_W-1:0]      latched_id, latched_id_next;
  logic [COUNT_W-1:0]   payload_count, payload_count_next;
  logic                 discard_rest, discard_rest_next;

  logic             is_digit;
  logic             is_space;
  logic [ACC_W-1:0] acc_times_ten;
  logic [ACC_W-1:0] acc_negated;

  assign is_digit      = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_space      = (rx_byte == CHAR_SPACE) || (rx_byte inside {[CHAR_TAB:CHAR_FORM_FEED]});
  assign acc_times_ten = (id_accumulator << 3) + (id_accumulator << 1);
  assign acc_negated   = ACC_W'(0) - id_accumulator;

  always_comb begin
    phase_next          = phase;
    id_char_count_next  = id_char_count;
    id_accumulator_next = id_accumulator;
    id_negative_next    = id_negative;
    id_scan_stage_next  = id_scan_stage;
    latched_id_next     = latched_id;
    payload_count_next  = payload_count;
    discard_rest_next   = discard_rest;
    res                 = '0;

    if (discard_rest) begin
      if (end_of_transfer) begin
        discard_rest_next = 1'b0;
      end
    end else if (phase == PH_ID) begin
      if (rx_byte == BYTE_ID_END) begin
        latched_id_next    = id_negative ? acc_negated[ID_W-1:0] : id_accumulator[ID_W-1:0];
        phase_next         = PH_PAYLOAD;
        payload_count_next = '0;
        if (end_of_transfer) begin
          phase_next = PH_NOSYNC;
          res.valid  = 1'b1;
          res.kind   = KIND_ERROR;
        end
      end else if (id_char_count >= ID_LIMIT) begin
        phase_next         = PH_NOSYNC;
        payload_count_next = '0;
        discard_rest_next  = !end_of_transfer;
        res.valid          = 1'b1;
        res.kind           = KIND_ERROR;
      end else begin
        id_char_count_next = id_char_count + 1'b1;
        if (id_scan_stage == ST_SPACE && is_space) begin
          id_scan_stage_next = ST_SPACE;
        end else if (id_scan_stage == ST_SPACE && rx_byte == CHAR_PLUS) begin
          id_scan_stage_next = ST_SIGNED;
        end else if (id_scan_stage == ST_SPACE && rx_byte == CHAR_MINUS) begin
          id_negative_next   = 1'b1;
          id_scan_stage_next = ST_SIGNED;
        end else if (id_scan_stage == ST_STOPPED) begin
          id_scan_stage_next = ST_STOPPED;
        end else if (is_digit) begin
          id_accumulator_next = acc_times_ten + ACC_W'(rx_byte - CHAR_ZERO);
          id_scan_stage_next  = ST_DIGITS;
        end else begin
          id_scan_stage_next = ST_STOPPED;
        end
        // A transfer that ends inside the id text breaks the frame.
        if (end_of_transfer) begin
          phase_next         = PH_NOSYNC;
          payload_count_next = '0;
          res.valid          = 1'b1;
          res.kind           = KIND_ERROR;
        end
      end
    end else if (phase == PH_PAYLOAD) begin
      if (rx_byte == BYTE_PAYLOAD_END) begin
        phase_next          = PH_ID;
        id_char_count_next  = '0;
        id_accumulator_next = '0;
        id_negative_next    = 1'b0;
        id_scan_stage_next  = ST_SPACE;
        payload_count_next  = '0;
        discard_rest_next   = !end_of_transfer;
        res.valid           = 1'b1;
        res.kind            = KIND_COMPLETE;
        res.message_id      = latched_id;
        res.byte_index      = INDEX_W'(payload_count);
      end else if (rx_byte == BYTE_PARTIAL_END) begin
        discard_rest_next = !end_of_transfer;
      end else if (payload_count >= CAP || end_of_transfer) begin
        phase_next         = PH_NOSYNC;
        payload_count_next = '0;
        discard_rest_next  = !end_of_transfer;
        res.valid          = 1'b1;
        res.kind           = KIND_ERROR;
      end else begin
        payload_count_next = payload_count + 1'b1;
        res.valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.message_id     = latched_id;
        res.payload_byte   = rx_byte;
        res.byte_index     = INDEX_W'(payload_count);
      end
    end else begin
      // Out of sync, including the unused phase code: only a terminator resyncs.
      phase_next = PH_NOSYNC;
      if (rx_byte == BYTE_PAYLOAD_END) begin
        phase_next          = PH_ID;
        id_char_count_next  = '0;
        id_accumulator_next = '0;
        id_negative_next    = 1'b0;
        id_scan_stage_next  = ST_SPACE;
        payload_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID;
      id_char_count  <= '0;
      id_accumulator <= '0;
      id_negative    <= 1'b0;
      id_scan_stage  <= ST_SPACE;
      latched_id     <= '0;
      payload_count  <= '0;
      discard_rest   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      id_char_count  <= id_char_count_next;
      id_accumulator <= id_accumulator_next;
      id_negative    <= id_negative_next;
      id_scan_stage  <= id_scan_stage_next;
      latched_id     <= latched_id_next;
      payload_count  <= payload_count_next;
      discard_rest   <= discard_rest_next;
    end
  end

endmodule

// ===== design/message_frame_receiver.sv =====
// Top level of the message frame receiver: input register, parser and result register.
//
//   Channel | Direction | Handshake           | Contents
//   s_*     | in        | s_tvalid / s_tready | s_tdata received byte, s_tlast end of transfer
//   m_*     | out       | m_tvalid / m_tready | m_tuser kind, m_tdata id, byte and index
//
// One byte per cycle is sustained while no result stalls; an accepted byte waits in the input
// register, and its result enters the result register when the single parser stage advances.
// Reset clears the valid flags and the parser state; no clearing pass is needed.
// A stalled result holds the parser, and the input register then fills and drops s_tready.
module message_frame_receiver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mfr_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] rx_byte
  input  logic                         s_tlast,  // end_of_transfer
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mfr_pkg::TDATA_W-1:0]  m_tdata,  // [15:0] message_id, [23:16] payload_byte,
                                                 // [30:24] byte_index, [31] zero
  output logic [mfr_pkg::KIND_W-1:0]   m_tuser   // [1:0] kind
);
  import mfr_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              advance;
  mfr_result_t       res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  mfr_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .rx_byte         (in_byte),
    .end_of_transfer (in_last),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {1'b0, res.byte_index, res.payload_byte, res.message_id};
      m_tuser <= res.kind;
    end
  end

endmodule

// ===== dv/message_frame_receiver_tb.sv =====
// Self-checking testbench for the message frame receiver, with a built-in frame parser model.
`timescale 1ns / 100ps

module message_frame_receiver_tb;
  import mfr_pkg::*;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_NOSYNC  = 2'd0,
    PH_ID      = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_SPACE   = 2'd0,
    SCAN_SIGNED  = 2'd1,
    SCAN_DIGITS  = 2'd2,
    SCAN_STOPPED = 2'd3
  } scan_t;

  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     message_id;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  byte_index;
  } frame_result_t;

  localparam logic [7:0] BYTE_PAYLOAD_END = 8'h00;
  localparam logic [7:0] BYTE_ID_END      = 8'h0D;
  localparam logic [7:0] BYTE_PARTIAL_END = 8'h0A;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_TAB         = 8'h09;
  localparam logic [7:0] CHAR_FORMFEED    = 8'h0C;
  localparam logic [7:0] CHAR_PLUS        = 8'h2B;
  localparam logic [7:0] CHAR_MINUS       = 8'h2D;
  localparam logic [7:0] CHAR_ZERO        = 8'h30;
  localparam logic [7:0] CHAR_NINE        = 8'h39;

  localparam int RANDOM_ITEMS       = 1385;
  localparam int OUTPUT_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int DRAIN_CYCLES       = 8;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [KIND_W-1:0]   m_tuser;

  message_frame_receiver DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Parser state as the block should hold it.
  phase_t              rx_phase;
  scan_t               scan_stage;
  int unsigned         id_chars;
  logic [ACC_W-1:0]    id_acc;
  bit                  id_neg;
  logic [ID_W-1:0]     held_id;
  int unsigned         held_count;
  bit                  skip_rest;

  frame_result_t       expected_results[$];
  int                  live_items;
  int                  mismatch_count;
  int                  completions_seen;
  int                  payload_seen;
  int                  errors_seen;
  bit                  sender_idle_on = 1'b1;
  bit                  hold_off_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void start_id_text();
    rx_phase   = PH_ID;
    id_chars   = 0;
    id_acc     = '0;
    id_neg     = 1'b0;
    scan_stage = SCAN_SPACE;
  endfunction

  function void reset_parser();
    start_id_text();
    held_id    = '0;
    held_count = 0;
    skip_rest  = 1'b0;
  endfunction

  function void push_frame_error(input logic last);
    frame_result_t r;
    rx_phase   = PH_NOSYNC;
    held_count = 0;
    skip_rest  = !last;
    r = '{KIND_ERROR, '0, '0, '0};
    expected_results.push_back(r);
  endfunction

  // Follows the atoi rules: whitespace, then one sign, then digits until a non-digit.
  function void scan_id_char(input logic [7:0] c);
    bit digit;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (scan_stage == SCAN_SPACE) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_FORMFEED)) return;
      if (c == CHAR_PLUS) begin
        scan_stage = SCAN_SIGNED;
        return;
      end
      if (c == CHAR_MINUS) begin
        id_neg     = 1'b1;
        scan_stage = SCAN_SIGNED;
        return;
      end
    end
    if (scan_stage == SCAN_STOPPED) return;
    if (digit) begin
      id_acc     = id_acc * 20'd10 + (ACC_W'(c) - ACC_W'(CHAR_ZERO));
      scan_stage = SCAN_DIGITS;
    end else begin
      scan_stage = SCAN_STOPPED;
    end
  endfunction

  function void predict_frame_result(input logic [7:0] c, input logic last);
    frame_result_t    r;
    logic [ACC_W-1:0] v;
    live_items++;
    if (skip_rest) begin
      if (last) skip_rest = 1'b0;
      return;
    end
    case (rx_phase)
      PH_ID: begin
        if (c == BYTE_ID_END) begin
          v = id_neg ? -id_acc : id_acc;
          held_id    = v[ID_W-1:0];
          rx_phase   = PH_PAYLOAD;
          held_count = 0;
          if (last) push_frame_error(last);
        end else if (id_chars >= ID_TEXT_LIMIT) begin
          push_frame_error(last);
        end else begin
          id_chars++;
          scan_id_char(c);
          if (last) push_frame_error(last);
        end
      end
      PH_PAYLOAD: begin
        if (c == BYTE_PAYLOAD_END) begin
          r = '{KIND_DONE, held_id, '0, INDEX_W'(held_count)};
          expected_results.push_back(r);
          start_id_text();
          held_count = 0;
          skip_rest  = !last;
        end else if (c == BYTE_PARTIAL_END) begin
          skip_rest = !last;
        end else if (held_count >= MESSAGE_CAPACITY || last) begin
          push_frame_error(last);
        end else begin
          r = '{KIND_DATA, held_id, c, INDEX_W'(held_count)};
          expected_results.push_back(r);
          held_count++;
        end
      end
      default: begin
        rx_phase = PH_NOSYNC;
        if (c == BYTE_PAYLOAD_END) begin
          start_id_text();
          held_count = 0;
        end
      end
    endcase
  endfunction

  // Offers one byte and waits for its transaction; valid stays high unless a gap follows.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_frame_result(b, last);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_frames();
    // Tab, minus sign and a stop at a non-digit; 0xFF payload, then a partial end
    // in mid-transfer whose remaining byte is dropped.
    send_byte(CHAR_TAB, 1'b0);
    send_byte("-", 1'b0);
    send_byte("9", 1'b0);
    send_byte("x", 1'b0);
    send_byte(BYTE_ID_END, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_PARTIAL_END, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(BYTE_PAYLOAD_END, 1'b1);
    // Six id characters are accepted and wrap; empty payload ended early.
    repeat (ID_TEXT_LIMIT) send_byte("9", 1'b0);
    send_byte(BYTE_ID_END, 1'b0);
    send_byte(BYTE_PAYLOAD_END, 1'b0);
    send_byte(8'h33, 1'b1);
    // Transfer ending on the id terminator, then resync on a final 0x00.
    send_byte("7", 1'b0);
    send_byte(BYTE_ID_END, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(BYTE_PAYLOAD_END, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_output_stall();
    bit idle_was;
    idle_was = sender_idle_on;
    sender_idle_on = 1'b0;
    hold_off_request = 1'b1;
    send_byte("5", 1'b0);
    send_byte(BYTE_ID_END, 1'b0);
    for (int i = 0; i < 40; i++) send_byte(8'(i + 1), 1'b0);
    send_byte(BYTE_PAYLOAD_END, 1'b1);
    sender_idle_on = idle_was;
    wait_for_drain();
  endtask

  function automatic logic [7:0] random_id_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 80) return ($urandom_range(0, 4) == 4) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(0, 3));
    if (r < 90) return ($urandom_range(0, 1) != 0) ? CHAR_PLUS : CHAR_MINUS;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_data_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == BYTE_PARTIAL_END) b = 8'hFF;
    return b;
  endfunction

  task automatic send_random_message();
    logic [7:0] id_text[$];
    int         n;
    int         len;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // Line noise with random transfer ends.
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
      return;
    end
    if (r < 16) begin
      // Id text one or two characters too long.
      n = $urandom_range(ID_TEXT_LIMIT + 1, ID_TEXT_LIMIT + 2);
      repeat (n) id_text.push_back(random_id_char());
    end else begin
      repeat ($urandom_range(0, 2))
        id_text.push_back(($urandom_range(0, 4) == 4) ? CHAR_SPACE
                                                      : CHAR_TAB + 8'($urandom_range(0, 3)));
      case ($urandom_range(0, 2))
        1: id_text.push_back(CHAR_PLUS);
        2: id_text.push_back(CHAR_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 5))
        if (id_text.size() < ID_TEXT_LIMIT) id_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if (id_text.size() < ID_TEXT_LIMIT && $urandom_range(0, 9) == 0)
        id_text.push_back(random_id_char());
    end
    foreach (id_text[i]) send_byte(id_text[i], $urandom_range(0, 99) < 3);
    send_byte(BYTE_ID_END, $urandom_range(0, 99) < 4);

    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 8);
    else if (r < 92) len = $urandom_range(9, MESSAGE_CAPACITY);
    else len = $urandom_range(MESSAGE_CAPACITY + 1, MESSAGE_CAPACITY + 6);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_byte(BYTE_PARTIAL_END, 1'b1);
      end else if (r < 6) begin
        send_byte(BYTE_PARTIAL_END, 1'b0);
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      send_byte(random_data_byte(), $urandom_range(0, 99) < 2);
    end

    if ($urandom_range(0, 99) < 85) begin
      send_byte(BYTE_PAYLOAD_END, 1'b1);
    end else begin
      send_byte(BYTE_PAYLOAD_END, 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_traffic();
    int start_items;
    int messages;
    start_items = live_items;
    messages = 0;
    while (live_items - start_items < RANDOM_ITEMS) begin
      sender_idle_on = ($urandom_range(0, 3) != 0);
      send_random_message();
      messages++;
      if (messages % 20 == 0) wait_for_drain();
    end
    sender_idle_on = 1'b1;
  endtask

  // Receiver side: random stalls in alternate stretches of the run, and one long hold-off.
  initial begin : output_ready_driver
    int stall;
    int cycles;
    stall = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (hold_off_request) begin
        m_tready <= 1'b0;
        repeat (OUTPUT_HOLD_CYCLES - 1) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if ((cycles / 256) % 2 == 1 && $urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_checker
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual kind %0d tdata %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind) begin
          mismatch_count++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser);
        end
        if (m_tdata[15:0] !== want.message_id) begin
          mismatch_count++;
          $display("%0t: message_id expected %0d actual %0d", $time,
                   $signed(want.message_id), $signed(m_tdata[15:0]));
        end
        if (m_tdata[23:16] !== want.payload_byte) begin
          mismatch_count++;
          $display("%0t: payload_byte expected %h actual %h", $time,
                   want.payload_byte, m_tdata[23:16]);
        end
        if (m_tdata[30:24] !== want.byte_index) begin
          mismatch_count++;
          $display("%0t: byte_index expected %0d actual %0d", $time,
                   want.byte_index, m_tdata[30:24]);
        end
        if (m_tdata[31] !== 1'b0) begin
          mismatch_count++;
          $display("%0t: tdata padding bit expected 0 actual %b", $time, m_tdata[31]);
        end
        case (want.kind)
          KIND_DATA: payload_seen++;
          KIND_DONE: completions_seen++;
          default:   errors_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count   = 0;
    completions_seen = 0;
    payload_seen     = 0;
    errors_seen      = 0;
    live_items       = 0;
    reset_parser();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_output_stall();
    test_random_traffic();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes: %0d payload bytes, %0d completed messages,",
             live_items, payload_seen, completions_seen);
    $display("%0d frame errors, with random stalls on both sides and a long output hold-off.",
             errors_seen);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
